FILE: hw/rtl/adsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_pkg
// Shared constants, types and helpers for the audio DAC sample FIFO.
// ----------------------------------------------------------------------------
package adsf_pkg;

	localparam int unsigned RING_DEPTH = 512;
	localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
	localparam int unsigned CODE_W     = 8;
	localparam int unsigned PCM_W      = 16;
	localparam int unsigned FILL_W     = 9;
	localparam int unsigned CNT_W      = 32;

	localparam logic [CODE_W-1:0] MIDSCALE = 8'd128;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic              wr_en;
		ptr_t              wr_addr;
		logic [CODE_W-1:0] wr_data;
		logic              rd_en;
		ptr_t              rd_addr;
	} adsf_mem_cmd_t;

	typedef struct packed {
		logic              pop_hit;
		logic              underrun;
		logic              overrun;
		logic [FILL_W-1:0] fill_level;
		logic [CNT_W-1:0]  underrun_total;
		logic [CNT_W-1:0]  overrun_total;
	} adsf_res_t;

	typedef struct packed {
		logic [CODE_W-1:0] dac_value;
		logic              underrun;
		logic              overrun;
		logic [FILL_W-1:0] fill_level;
		logic [CNT_W-1:0]  underrun_total;
		logic [CNT_W-1:0]  overrun_total;
	} adsf_beat_t;

	function automatic ptr_t adsf_advance(input ptr_t pos);
		return (pos == ptr_t'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
	endfunction

endpackage

FILE: hw/rtl/adsf_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_item_if
// Input channel: one push or DAC tick per beat.
// ----------------------------------------------------------------------------
interface adsf_item_if;
	import adsf_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    func;
	logic signed [PCM_W-1:0] pcm_sample;

	modport source(output valid, output func, output pcm_sample, input ready);
	modport sink(input valid, input func, input pcm_sample, output ready);
endinterface

FILE: hw/rtl/adsf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_result_if
// Output channel: one result beat per input beat.
// ----------------------------------------------------------------------------
interface adsf_result_if;
	import adsf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] dac_value;
	logic              underrun;
	logic              overrun;
	logic [FILL_W-1:0] fill_level;
	logic [CNT_W-1:0]  underrun_total;
	logic [CNT_W-1:0]  overrun_total;

	modport source(output valid, output dac_value, output underrun, output overrun,
		output fill_level, output underrun_total, output overrun_total, input ready);
	modport sink(input valid, input dac_value, input underrun, input overrun,
		input fill_level, input underrun_total, input overrun_total, output ready);
endinterface

FILE: hw/rtl/adsf_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_ring_mem
// Sample ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module adsf_ring_mem (
	input  logic                                 clk,
	input  adsf_pkg::adsf_mem_cmd_t              mem_cmd,
	output logic [adsf_pkg::CODE_W-1:0]          rd_data
);
	import adsf_pkg::*;

	logic [CODE_W-1:0] mem [RING_DEPTH];
	logic [CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_cmd.wr_en) begin
			mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
		end
		if (mem_cmd.rd_en) begin
			rd_data_q <= mem[mem_cmd.rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: hw/rtl/adsf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_ctrl
// Ring positions, fill count and error counters; issues memory accesses.
// ----------------------------------------------------------------------------
module adsf_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic                                 func,
	input  logic signed [adsf_pkg::PCM_W-1:0]    pcm_sample,
	output adsf_pkg::adsf_mem_cmd_t              mem_cmd,
	output adsf_pkg::adsf_res_t                  res
);
	import adsf_pkg::*;

	ptr_t             rd_ptr_q;
	ptr_t             wr_ptr_q;
	ptr_t             cnt_q;
	logic [CNT_W-1:0] udr_cnt_q;
	logic [CNT_W-1:0] ovr_cnt_q;

	ptr_t             wr_next;
	ptr_t             cnt_next;
	logic             push;
	logic             tick;
	logic             full;
	logic             empty;
	logic             push_ok;
	logic             pop_ok;
	logic             udr_hit;
	logic             ovr_hit;
	logic [CNT_W-1:0] udr_next;
	logic [CNT_W-1:0] ovr_next;

	always_comb begin
		push     = accept && (func == FUNC_PUSH);
		tick     = accept && (func == FUNC_TICK);
		wr_next  = adsf_advance(wr_ptr_q);
		full     = (wr_next == rd_ptr_q);
		empty    = (rd_ptr_q == wr_ptr_q);
		push_ok  = push && !full;
		pop_ok   = tick && !empty;
		ovr_hit  = push && full;
		udr_hit  = tick && empty;
		udr_next = udr_cnt_q + CNT_W'(udr_hit);
		ovr_next = ovr_cnt_q + CNT_W'(ovr_hit);

		cnt_next = cnt_q;
		if (push_ok) begin
			cnt_next = cnt_q + 1'b1;
		end else if (pop_ok) begin
			cnt_next = cnt_q - 1'b1;
		end
	end

	// Adding 32768 and keeping the top byte is the high byte with its sign flipped.
	always_comb begin
		mem_cmd.wr_en   = push_ok;
		mem_cmd.wr_addr = wr_ptr_q;
		mem_cmd.wr_data = {~pcm_sample[PCM_W-1], pcm_sample[PCM_W-2:PCM_W-CODE_W]};
		mem_cmd.rd_en   = pop_ok;
		mem_cmd.rd_addr = rd_ptr_q;
	end

	always_comb begin
		res.pop_hit        = pop_ok;
		res.underrun       = udr_hit;
		res.overrun        = ovr_hit;
		res.fill_level     = FILL_W'(cnt_next);
		res.underrun_total = udr_next;
		res.overrun_total  = ovr_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			cnt_q     <= '0;
			udr_cnt_q <= '0;
			ovr_cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_next;
			end
			if (pop_ok) begin
				rd_ptr_q <= adsf_advance(rd_ptr_q);
			end
			cnt_q     <= cnt_next;
			udr_cnt_q <= udr_next;
			ovr_cnt_q <= ovr_next;
		end
	end
endmodule

FILE: hw/rtl/adsf_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_out_stage
// Result stage that merges the memory read data, with a skid register.
// ----------------------------------------------------------------------------
module adsf_out_stage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  adsf_pkg::adsf_res_t                  res,
	input  logic [adsf_pkg::CODE_W-1:0]          rd_data,
	output logic                                 can_accept,
	adsf_result_if.source                        result
);
	import adsf_pkg::*;

	logic       valid_s1;
	adsf_res_t  res_s1;
	logic       skid_valid_q;
	adsf_beat_t skid_q;
	adsf_beat_t head_s1;
	adsf_beat_t beat;
	logic       take;

	always_comb begin
		head_s1.dac_value      = res_s1.pop_hit ? rd_data : MIDSCALE;
		head_s1.underrun       = res_s1.underrun;
		head_s1.overrun        = res_s1.overrun;
		head_s1.fill_level     = res_s1.fill_level;
		head_s1.underrun_total = res_s1.underrun_total;
		head_s1.overrun_total  = res_s1.overrun_total;
		// The skid register always holds the older beat when both are full.
		beat                   = skid_valid_q ? skid_q : head_s1;
	end

	assign take       = result.valid && result.ready;
	assign can_accept = !skid_valid_q;

	assign result.valid          = skid_valid_q || valid_s1;
	assign result.dac_value      = beat.dac_value;
	assign result.underrun       = beat.underrun;
	assign result.overrun        = beat.overrun;
	assign result.fill_level     = beat.fill_level;
	assign result.underrun_total = beat.underrun_total;
	assign result.overrun_total  = beat.overrun_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (valid_s1 && !take) begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && accept) begin
			res_s1 <= res;
			if (valid_s1 && !take) begin
				skid_q <= head_s1;
			end
		end
	end
endmodule

FILE: hw/rtl/audio_dac_sample_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_dac_sample_fifo_top
// Sample FIFO between an audio producer and a DAC, with error counters.
// ----------------------------------------------------------------------------
// Each input beat is a push of a signed 16-bit PCM sample (stored as an 8-bit
// DAC code) or a DAC tick that pops the oldest code; every beat yields exactly
// one result beat carrying the code (128 on a push or on an empty ring), the
// underrun/overrun flags, the fill level after the beat and both 32-bit
// wrapping totals. The ring holds RING_DEPTH - 1 codes in a single-port-write,
// single-port-read memory. A result is registered in the output stage together
// with the registered read data of the sample memory, and the block takes
// one beat per cycle while the result side keeps up. A skid register holds one
// stalled result, so input ready drops only when two results are waiting. No
// clearing pass is needed after reset; the block is ready at once.
module audio_dac_sample_fifo_top (
	input  logic         clk,
	input  logic         arst_n,
	adsf_item_if.sink    item,
	adsf_result_if.source result
);
	import adsf_pkg::*;

	adsf_mem_cmd_t     mem_cmd;
	adsf_res_t         res;
	logic [CODE_W-1:0] rd_data;
	logic              can_accept;
	logic              accept;

	assign item.ready = can_accept;
	assign accept     = item.valid && can_accept;

	adsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (item.func),
		.pcm_sample (item.pcm_sample),
		.mem_cmd    (mem_cmd),
		.res        (res)
	);

	adsf_ring_mem u_ring_mem (
		.clk     (clk),
		.mem_cmd (mem_cmd),
		.rd_data (rd_data)
	);

	adsf_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.res        (res),
		.rd_data    (rd_data),
		.can_accept (can_accept),
		.result     (result)
	);
endmodule

FILE: hw/rtl/adsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsf_checker
// Port-level checks on the result channel of the sample FIFO.
// ----------------------------------------------------------------------------
module adsf_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	input  logic                              ready,
	input  logic [adsf_pkg::CODE_W-1:0]       dac_value,
	input  logic                              underrun,
	input  logic                              overrun,
	input  logic [adsf_pkg::FILL_W-1:0]       fill_level,
	input  logic [adsf_pkg::CNT_W-1:0]        underrun_total,
	input  logic [adsf_pkg::CNT_W-1:0]        overrun_total
);
	import adsf_pkg::*;

	// An underrun reports midscale and an empty ring.
	a_underrun_midscale: assert property (@(posedge clk) disable iff (!arst_n)
		valid && underrun |-> (dac_value == MIDSCALE) && (fill_level == '0))
		else $error("underrun beat without midscale code or with a nonempty ring");

	// A dropped sample means the ring was at capacity and stays there.
	a_overrun_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid && overrun |-> fill_level == FILL_W'(RING_DEPTH - 1))
		else $error("overrun beat while the ring was not full");

	// One beat is either a push or a tick, so both flags never rise together.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !(underrun && overrun))
		else $error("underrun and overrun flagged on the same beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(dac_value) && $stable(fill_level)
			&& $stable(underrun_total) && $stable(overrun_total))
		else $error("stalled result beat changed");
endmodule

bind audio_dac_sample_fifo_top adsf_checker u_adsf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (result.valid),
	.ready          (result.ready),
	.dac_value      (result.dac_value),
	.underrun       (result.underrun),
	.overrun        (result.overrun),
	.fill_level     (result.fill_level),
	.underrun_total (result.underrun_total),
	.overrun_total  (result.overrun_total)
);
